>>> hw/rtl/lrpf_pkg.sv
`timescale 1ns / 1ps
package lrpf_pkg;

    localparam int unsigned PAGE_BYTES = 4096;
    localparam int unsigned AW = $clog2(PAGE_BYTES);
    localparam int unsigned PW = AW + 1;
    localparam int unsigned HDR_BYTES = 18;
    localparam int unsigned TLR_BYTES = 4;
    localparam int unsigned CLOSE_LIMIT = HDR_BYTES + 2 * TLR_BYTES;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [63:0] REC_MAGIC = 64'h4243_4552_4C41_5744;

    localparam logic [2:0] REQ_APPEND = 3'd0;
    localparam logic [2:0] REQ_FINAL  = 3'd1;
    localparam logic [2:0] REQ_FLUSH  = 3'd2;
    localparam logic [2:0] REQ_DONE   = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOSPACE = 3'd1;
    localparam logic [2:0] ST_BUSY    = 3'd2;
    localparam logic [2:0] ST_NOFLUSH = 3'd3;
    localparam logic [2:0] ST_WFAIL   = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  data_byte;
        logic        end_of_op;
        logic [11:0] read_addr;
        logic        write_ok;
    } lrpf_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] space_left;
        logic [12:0] page_wr_end;
        logic [12:0] page_commit_end;
        logic        start_write;
        logic [63:0] record_seq;
        logic [31:0] record_crc;
        logic [12:0] waste_bytes;
        logic [12:0] ops_committed;
        logic [7:0]  read_data;
        logic        page_recycled;
    } lrpf_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HDR,
        S_DATA,
        S_LEN,
        S_CRC_RD,
        S_CRC_WAIT,
        S_CRC_BIT,
        S_TLR,
        S_RD_WAIT,
        S_OUT
    } lrpf_state_t;

    // one bit step of the reflected crc
    function automatic logic [31:0] crc_bit(input logic [31:0] c);
        crc_bit = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    endfunction

endpackage

>>> hw/rtl/lrpf_page_ram.sv
`timescale 1ns / 1ps
module lrpf_page_ram
    import lrpf_pkg::*;
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [PAGE_BYTES];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/log_record_page_framer_unit.sv
`timescale 1ns / 1ps
// channel | dir | signals
// in      | in  | in_valid, in_ready, in_data (lrpf_in_t)
// out     | out | out_valid, out_ready, out_data (lrpf_out_t)
// one word at a time; in_ready is low from acceptance until the result is taken.
// append: a data byte write and two length writes; opening a record adds 16 header writes.
// flush/close: the crc walks header and payload one byte at a time through the page
// ram read port, bit-serial, then 4 trailer writes.
// reset clears state, positions, writing flag, seq, length, op count; not the page ram.
module log_record_page_framer_unit
    import lrpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  lrpf_in_t  in_data,
    input  logic      out_ready,
    output logic      out_valid,
    output lrpf_out_t out_data
);

    lrpf_state_t state_reg, state_next;
    lrpf_in_t    req_reg, req_next;
    logic [PW-1:0] wpos_reg, wpos_next;
    logic [PW-1:0] cpos_reg, cpos_next;
    logic          writing_reg, writing_next;
    logic [63:0]   seq_reg, seq_next;
    logic [15:0]   rlen_reg, rlen_next;
    logic [12:0]   pend_reg, pend_next;
    logic [31:0]   crc_reg, crc_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [2:0]    bit_reg, bit_next;
    logic          close_reg, close_next;
    lrpf_out_t     res_reg, res_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    lrpf_page_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [PW-1:0] need_w, space_w, sp_addr, rec_n, wr_pos;
    logic          room_w;

    // space left from current state
    always_comb
    begin
        need_w = (cpos_reg == wpos_reg) ? PW'(HDR_BYTES + TLR_BYTES) : PW'(TLR_BYTES);
        room_w = !writing_reg && (wpos_reg < PW'(PAGE_BYTES))
                 && ((PW'(PAGE_BYTES) - wpos_reg) > need_w);
        space_w = room_w ? (PW'(PAGE_BYTES) - wpos_reg - need_w) : '0;
        rec_n = PW'(HDR_BYTES) + PW'(rlen_reg);
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // result word: late fields follow the state, which holds while in S_OUT
    always_comb
    begin
        out_data = res_reg;
        out_data.space_left = (space_w > PW'(4095)) ? 12'hFFF : 12'(space_w);
        out_data.page_wr_end = 13'(wpos_reg);
        out_data.page_commit_end = 13'(cpos_reg);
        out_data.record_seq = seq_reg - 64'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wpos_reg    <= '0;
            cpos_reg    <= '0;
            writing_reg <= 1'b0;
            seq_reg     <= '0;
            rlen_reg    <= '0;
            pend_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            wpos_reg    <= wpos_next;
            cpos_reg    <= cpos_next;
            writing_reg <= writing_next;
            seq_reg     <= seq_next;
            rlen_reg    <= rlen_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        crc_reg   <= crc_next;
        cnt_reg   <= cnt_next;
        bit_reg   <= bit_next;
        close_reg <= close_next;
        res_reg   <= res_next;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        wpos_next    = wpos_reg;
        cpos_next    = cpos_reg;
        writing_next = writing_reg;
        seq_next     = seq_reg;
        rlen_next    = rlen_reg;
        pend_next    = pend_reg;
        crc_next     = crc_reg;
        cnt_next     = cnt_reg;
        bit_next     = bit_reg;
        close_next   = close_reg;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;
        sp_addr      = '0;
        wr_pos       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = in_data;
                    res_next = '0;
                    cnt_next = '0;
                    close_next = 1'b0;
                    case (in_data.req_type)
                        REQ_APPEND, REQ_FINAL:
                        begin
                            if (writing_reg)
                            begin
                                res_next.status = ST_BUSY;
                                state_next = S_OUT;
                            end
                            else if (space_w == '0)
                            begin
                                res_next.status = ST_NOSPACE;
                                state_next = S_OUT;
                            end
                            else if (cpos_reg == wpos_reg)
                            begin
                                rlen_next = '0;
                                state_next = S_HDR;
                            end
                            else
                            begin
                                state_next = S_DATA;
                            end
                        end
                        REQ_FLUSH:
                        begin
                            if (writing_reg)
                            begin
                                res_next.status = ST_BUSY;
                                state_next = S_OUT;
                            end
                            else if (wpos_reg == cpos_reg)
                            begin
                                res_next.status = ST_NOFLUSH;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                crc_next = '1;
                                state_next = S_CRC_RD;
                            end
                        end
                        REQ_DONE:
                        begin
                            if (writing_reg)
                            begin
                                writing_next = 1'b0;
                                if (in_data.write_ok)
                                begin
                                    res_next.waste_bytes =
                                        13'(PW'(PAGE_BYTES) - (wpos_reg - cpos_reg));
                                    res_next.ops_committed = pend_reg;
                                    pend_next = '0;
                                    rlen_next = '0;
                                    if (wpos_reg == PW'(PAGE_BYTES))
                                    begin
                                        cpos_next = '0;
                                        wpos_next = '0;
                                        res_next.page_recycled = 1'b1;
                                    end
                                    else
                                    begin
                                        cpos_next = wpos_reg;
                                    end
                                end
                                else
                                begin
                                    res_next.status = ST_WFAIL;
                                    wpos_next = cpos_reg + rec_n;
                                end
                            end
                            state_next = S_OUT;
                        end
                        REQ_READ:
                        begin
                            if (PW'(in_data.read_addr) < wpos_reg)
                            begin
                                state_next = S_RD_WAIT;
                            end
                            else
                            begin
                                state_next = S_OUT;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            // header bytes, one write a cycle
            S_HDR:
            begin
                sp_addr = cpos_reg + cnt_reg;
                ram_we = (sp_addr < PW'(PAGE_BYTES));
                ram_waddr = sp_addr[AW-1:0];
                if (cnt_reg < PW'(8))
                begin
                    ram_wdata = REC_MAGIC[cnt_reg[2:0]*8 +: 8];
                end
                else
                begin
                    ram_wdata = seq_reg[cnt_reg[2:0]*8 +: 8];
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == PW'(15))
                begin
                    seq_next = seq_reg + 64'd1;
                    wpos_next = cpos_reg + PW'(HDR_BYTES);
                    state_next = S_DATA;
                end
            end

            S_DATA:
            begin
                ram_we = (wpos_reg < PW'(PAGE_BYTES));
                ram_waddr = wpos_reg[AW-1:0];
                ram_wdata = req_reg.data_byte;
                wpos_next = wpos_reg + 1'b1;
                rlen_next = rlen_reg + 16'd1;
                cnt_next = '0;
                state_next = S_LEN;
            end

            // length field, low then high
            S_LEN:
            begin
                sp_addr = cpos_reg + PW'(16) + cnt_reg;
                ram_we = (sp_addr < PW'(PAGE_BYTES));
                ram_waddr = sp_addr[AW-1:0];
                ram_wdata = cnt_reg[0] ? rlen_reg[15:8] : rlen_reg[7:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[0])
                begin
                    state_next = S_OUT;
                    if (req_reg.end_of_op)
                    begin
                        if (pend_reg != 13'h1FFF)
                        begin
                            pend_next = pend_reg + 13'd1;
                        end
                        if (req_reg.req_type == REQ_FINAL)
                        begin
                            close_next = 1'b1;
                            crc_next = '1;
                            cnt_next = '0;
                            state_next = S_CRC_RD;
                        end
                    end
                end
            end

            S_CRC_RD:
            begin
                if (cnt_reg == rec_n)
                begin
                    cnt_next = '0;
                    state_next = S_TLR;
                end
                else
                begin
                    ram_raddr = 12'(cpos_reg + cnt_reg);
                    state_next = S_CRC_WAIT;
                end
            end

            S_CRC_WAIT:
            begin
                sp_addr = cpos_reg + cnt_reg;
                crc_next = crc_reg ^ ((sp_addr < PW'(PAGE_BYTES)) ? {24'd0, ram_rdata} : 32'd0);
                bit_next = '0;
                state_next = S_CRC_BIT;
            end

            S_CRC_BIT:
            begin
                crc_next = crc_bit(crc_reg);
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    state_next = S_CRC_RD;
                end
            end

            // trailer bytes, then position update
            S_TLR:
            begin
                sp_addr = cpos_reg + rec_n + cnt_reg;
                ram_we = (sp_addr < PW'(PAGE_BYTES));
                ram_waddr = sp_addr[AW-1:0];
                ram_wdata = ~crc_reg[cnt_reg[1:0]*8 +: 8];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == PW'(3))
                begin
                    res_next.record_crc = ~crc_reg;
                    res_next.start_write = 1'b1;
                    writing_next = 1'b1;
                    wr_pos = wpos_reg + PW'(TLR_BYTES);
                    if (close_reg || (wpos_reg >= PW'(PAGE_BYTES))
                        || ((PW'(PAGE_BYTES) - wpos_reg) <= PW'(CLOSE_LIMIT)))
                    begin
                        wpos_next = PW'(PAGE_BYTES);
                    end
                    else
                    begin
                        wpos_next = wr_pos;
                    end
                    state_next = S_OUT;
                end
            end

            S_RD_WAIT:
            begin
                ram_raddr = req_reg.read_addr;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[0])
                begin
                    res_next.read_data = ram_rdata;
                    state_next = S_OUT;
                end
            end

            // hold result until taken
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
